// ===== hdl/psg_pkg.sv =====
// shared types and constants for the permutation sequence generator
// no dependencies; imported by psg_ctrl, psg_dpath and the top level

package psg_pkg;

   // fixed field widths
   localparam int unsigned CNT_W   = 7;
   localparam int unsigned POS_W   = 6;
   localparam int unsigned VAL_W   = 7;
   localparam int unsigned DIGIT_W = 6;

   // defaults
   localparam int unsigned       DEFAULT_MAX_ITEMS = 16;
   localparam logic [CNT_W-1:0]  ITEM_COUNT_RESET  = 7'd4;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_MORE = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   // commands from controller to datapath
   typedef struct packed {
      logic start;         // request taken, begin digit walk
      logic fresh;         // clear the counter instead of stepping it
      logic walk;          // process one digit and insert one item
      logic load_elem;     // move next permutation element to the output word
      logic load_invalid;  // load the invalid-argument word
   } psg_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic n_bad;         // item count zero or above capacity
      logic walk_last;     // current digit is the top one
      logic emit_last;     // next element out is the final one
      logic out_free;      // output register can take a word this cycle
   } psg_stat_type;

endpackage

// ===== hdl/permutation_sequence_generator.sv =====
// Factorial-counter permutation generator. Each request word either restarts the
// counter (first permutation n..1) or steps it, then returns the permutation of
// 1..n as n result words in position order, the last one flagged; a wrap of the
// top digit reports no_more. An accepted request runs the digit walk (one digit
// is read from the digit memory, carried and inserted into the list per cycle),
// then shifts the list out, one word per cycle while the consumer takes them; no
// request is taken until the last word is loaded. An item count of zero or above
// MAX_ITEMS gives one invalid_arg word. The user writes the item count through
// the csr port while idle, followed by a restart; the block does not enforce it.
//
// top level; depends on psg_pkg, psg_ctrl and psg_dpath

module permutation_sequence_generator import psg_pkg::*; #(
   parameter int unsigned MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CNT_W-1:0]   csr_item_count,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [POS_W-1:0]   rsp_position,
   output logic [VAL_W-1:0]   rsp_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   psg_cmd_type  cmd;
   psg_stat_type stat;

   // register write always accepted
   assign csr_ready = 1'b1;

   psg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   psg_dpath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid && csr_ready),
      .csr_item_count (csr_item_count),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_position   (rsp_position),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   // a taken request blocks the next one
   a_req_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one still in progress");

   // invalid word is a lone word at position zero
   a_invalid_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INVALID |->
         rsp_last && rsp_position == '0 && rsp_value == '0)
      else $error("malformed invalid_arg word");

   // good words always carry an item number
   a_value_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_INVALID |-> rsp_value != '0)
      else $error("permutation element with value zero");

   // elements of one request come out at consecutive positions
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         !rsp_valid || rsp_position == POS_W'($past(rsp_position) + POS_W'(1)))
      else $error("permutation position skipped or repeated");

endmodule

// ===== hdl/psg_ctrl.sv =====
// sequencing state machine for the permutation sequence generator
// depends on psg_pkg; drives psg_dpath through command and status structs

module psg_ctrl import psg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_restart,
   output logic         req_stall,
   input  psg_stat_type stat,
   output psg_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_EMIT,
      S_BAD
   } state_type;

   state_type state_ff;
   logic      needs_init_ff;

   // only idle takes a new word
   assign req_stall = (state_ff != S_IDLE);

   // command decode
   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !stat.n_bad) begin
               cmd.start = 1'b1;
               cmd.fresh = req_restart || needs_init_ff;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
         end
         S_EMIT: begin
            cmd.load_elem = stat.out_free;
         end
         S_BAD: begin
            cmd.load_invalid = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // state and init flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         needs_init_ff <= 1'b1;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (stat.n_bad) begin
                     state_ff <= S_BAD;
                  end else begin
                     state_ff      <= S_WALK;
                     needs_init_ff <= 1'b0;
                  end
               end
            end
            S_WALK: begin
               if (stat.walk_last) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (stat.out_free && stat.emit_last) begin
                  state_ff <= S_IDLE;
               end
            end
            S_BAD: begin
               if (stat.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hdl/psg_dpath.sv =====
// datapath: digit memory, ripple carry, insertion list and output word
// depends on psg_pkg; commanded by psg_ctrl

module psg_dpath import psg_pkg::*; #(
   parameter int unsigned MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [CNT_W-1:0]   csr_item_count,
   input  psg_cmd_type        cmd,
   output psg_stat_type       stat,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [POS_W-1:0]   rsp_position,
   output logic [VAL_W-1:0]   rsp_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   localparam int unsigned      IDX_W = $clog2(MAX_ITEMS);
   localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_ITEMS);
   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(MAX_ITEMS - 1);

   logic [CNT_W-1:0]   item_count_ff;

   logic [DIGIT_W-1:0] digit_mem [MAX_ITEMS];
   logic [MAX_ITEMS-1:0] dvalid_ff;
   logic [DIGIT_W-1:0] rd_data_ff;
   logic               rd_valid_ff;
   logic [IDX_W-1:0]   rd_addr;

   logic [IDX_W-1:0]   k_ff;
   logic [IDX_W-1:0]   pos_ff;
   logic               carry_ff;
   logic               wrap_ff;

   logic [VAL_W-1:0]   slot_ff   [MAX_ITEMS];
   logic [VAL_W-1:0]   slot_in   [MAX_ITEMS];
   logic [VAL_W-1:0]   slot_prev [MAX_ITEMS];
   logic [VAL_W-1:0]   slot_after[MAX_ITEMS];

   logic               rsp_valid_ff;
   logic [POS_W-1:0]   rsp_position_ff;
   logic [VAL_W-1:0]   rsp_value_ff;
   status_type         rsp_status_ff;
   logic               rsp_last_ff;

   logic [DIGIT_W-1:0] digit_cur;
   logic [DIGIT_W-1:0] digit_sum;
   logic [DIGIT_W-1:0] digit_new;
   logic [CNT_W-1:0]   radix;
   logic               trip;
   logic               top;
   logic               load;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= ITEM_COUNT_RESET;
      end else if (csr_valid) begin
         item_count_ff <= csr_item_count;
      end
   end

   // one counter digit per walk cycle: add carry, wrap at its radix
   always_comb begin
      digit_cur = rd_valid_ff ? rd_data_ff : '0;
      digit_sum = digit_cur + DIGIT_W'(carry_ff);
      radix     = CNT_W'(k_ff) + CNT_W'(1);
      trip      = (CNT_W'(digit_sum) >= radix);
      top       = (radix == item_count_ff);
      digit_new = trip ? '0 : digit_sum;
   end

   // read the next digit ahead of its use
   assign rd_addr = (cmd.start || k_ff == TOP_IDX) ? '0 : k_ff + IDX_W'(1);

   // digit memory with registered read
   always_ff @(posedge clock) begin
      if (cmd.walk) begin
         digit_mem[k_ff] <= digit_new;
      end
      rd_data_ff <= digit_mem[rd_addr];
   end

   // digit valid bits, cleared on restart
   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= dvalid_ff[rd_addr] && !(cmd.start && cmd.fresh);
         if (cmd.start && cmd.fresh) begin
            dvalid_ff <= '0;
         end else if (cmd.walk) begin
            dvalid_ff[k_ff] <= 1'b1;
         end
      end
   end

   // walk and emit counters, carry and wrap flag
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         pos_ff   <= '0;
         carry_ff <= 1'b0;
         wrap_ff  <= 1'b0;
      end else begin
         if (cmd.start) begin
            k_ff     <= '0;
            pos_ff   <= '0;
            carry_ff <= !cmd.fresh;
            wrap_ff  <= 1'b0;
         end else begin
            if (cmd.walk) begin
               k_ff     <= k_ff + IDX_W'(1);
               carry_ff <= trip && !top;
               wrap_ff  <= wrap_ff || (trip && top);
            end
            if (cmd.load_elem) begin
               pos_ff <= pos_ff + IDX_W'(1);
            end
         end
      end
   end

   // neighbor taps of the insertion list
   for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_tap
      if (g == 0) begin : g_first
         assign slot_prev[g] = slot_ff[g];
      end else begin : g_rest
         assign slot_prev[g] = slot_ff[g-1];
      end
      if (g == MAX_ITEMS - 1) begin : g_end
         assign slot_after[g] = slot_ff[g];
      end else begin : g_mid
         assign slot_after[g] = slot_ff[g+1];
      end
   end

   // insert item k+1 at rank digit_new, or shift out toward slot 0
   always_comb begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         slot_in[i] = slot_ff[i];
         if (cmd.walk) begin
            if (CNT_W'(i) == CNT_W'(digit_new)) begin
               slot_in[i] = VAL_W'(radix);
            end else if (CNT_W'(i) > CNT_W'(digit_new)) begin
               slot_in[i] = slot_prev[i];
            end
         end else if (cmd.load_elem) begin
            slot_in[i] = slot_after[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   // output word register
   assign load = cmd.load_elem || cmd.load_invalid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_invalid) begin
         rsp_position_ff <= '0;
         rsp_value_ff    <= '0;
         rsp_status_ff   <= ST_INVALID;
         rsp_last_ff     <= 1'b1;
      end else if (cmd.load_elem) begin
         rsp_position_ff <= POS_W'(pos_ff);
         rsp_value_ff    <= slot_ff[0];
         rsp_status_ff   <= wrap_ff ? ST_NO_MORE : ST_OK;
         rsp_last_ff     <= stat.emit_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

   // status to controller
   always_comb begin
      stat.n_bad     = (item_count_ff == '0) || (item_count_ff > MAX_N);
      stat.walk_last = top;
      stat.emit_last = ((CNT_W'(pos_ff) + CNT_W'(1)) == item_count_ff);
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// ===== sim/tb.sv =====
// testbench for permutation_sequence_generator: directed table, then random phases
// results are checked word by word against a factorial-counter predictor
// depends on psg_pkg and the permutation_sequence_generator rtl

module tb;
   import psg_pkg::*;

   localparam int unsigned MAX_ITEMS = DEFAULT_MAX_ITEMS;
   localparam int NO_WRITE = -1;
   // cycles a request may still be in flight after its last word
   localparam int SETTLE = 2 * MAX_ITEMS + 4;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASES = 9;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
      status_type       status;
      logic             last;
   } perm_word_t;

   typedef struct {
      int         cfg;
      bit         restart;
      bit         typed;
      status_type status;
   } plan_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CNT_W-1:0] csr_item_count = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [POS_W-1:0] rsp_position;
   logic [VAL_W-1:0] rsp_value;
   logic [1:0] rsp_status;
   logic rsp_last;

   // predictor state
   logic [DIGIT_W-1:0] counter_digits [MAX_ITEMS];
   logic               counter_fresh;
   logic [CNT_W-1:0]   model_count;

   perm_word_t pending_words [$];
   perm_word_t discarded_words [$];

   int mismatches = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_asked = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   // directed plan: count write before the word, restart bit, typed expectation
   plan_row_t directed_rows [25] = '{
      '{NO_WRITE, 1'b0, 1'b1, ST_OK},       // first word after reset acts as restart
      '{NO_WRITE, 1'b0, 1'b0, ST_OK},
      '{NO_WRITE, 1'b0, 1'b0, ST_OK},
      '{NO_WRITE, 1'b1, 1'b1, ST_OK},       // restart gives n..1
      '{0,        1'b0, 1'b1, ST_INVALID},  // zero items
      '{17,       1'b1, 1'b1, ST_INVALID},  // just above capacity
      '{64,       1'b0, 1'b1, ST_INVALID},  // above capacity, inside the 7-bit field
      '{1,        1'b1, 1'b1, ST_OK},
      '{NO_WRITE, 1'b0, 1'b1, ST_NO_MORE},  // one item always wraps
      '{NO_WRITE, 1'b0, 1'b1, ST_NO_MORE},
      '{2,        1'b1, 1'b1, ST_OK},
      '{NO_WRITE, 1'b0, 1'b0, ST_OK},
      '{NO_WRITE, 1'b0, 1'b0, ST_OK},       // wrap with two items
      '{3,        1'b1, 1'b1, ST_OK},
      '{NO_WRITE, 1'b0, 1'b0, ST_OK},
      '{NO_WRITE, 1'b0, 1'b0, ST_OK},
      '{NO_WRITE, 1'b0, 1'b0, ST_OK},
      '{NO_WRITE, 1'b0, 1'b0, ST_OK},
      '{NO_WRITE, 1'b0, 1'b0, ST_OK},
      '{NO_WRITE, 1'b0, 1'b0, ST_OK},       // wrap with three items
      '{16,       1'b1, 1'b1, ST_OK},       // full capacity
      '{NO_WRITE, 1'b0, 1'b0, ST_OK},
      '{NO_WRITE, 1'b0, 1'b0, ST_OK},
      '{5,        1'b0, 1'b0, ST_OK},       // count changed without restart
      '{63,       1'b0, 1'b1, ST_INVALID}
   };

   int phase_counts [PHASES] = '{4, 3, 16, 2, 1, 6, 0, 5, 8};

   permutation_sequence_generator #(.MAX_ITEMS(MAX_ITEMS)) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_item_count (csr_item_count),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_position   (rsp_position),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   // clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task automatic check_field(input string field, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
   endtask

   // step or clear the factorial counter, then decode it into words
   task automatic step_and_decode(input bit restart, ref perm_word_t dst [$]);
      int unsigned n;
      int unsigned rank;
      int unsigned seen;
      int j;
      int l;
      int p;
      status_type st;
      logic [VAL_W-1:0] perm [MAX_ITEMS];
      bit filled [MAX_ITEMS];
      n = model_count;
      st = ST_OK;
      if (n == 0 || n > MAX_ITEMS) begin
         dst.push_back('{position: '0, value: '0, status: ST_INVALID, last: 1'b1});
         return;
      end
      if (restart || counter_fresh) begin
         foreach (counter_digits[k]) counter_digits[k] = '0;
         counter_fresh = 1'b0;
      end else begin
         counter_digits[0] = counter_digits[0] + 1'b1;
         for (j = 1; j <= n; j++) begin
            if (counter_digits[j-1] >= j) begin
               counter_digits[j-1] = '0;
               if (j >= n) st = ST_NO_MORE;
               else counter_digits[j] = counter_digits[j] + 1'b1;
            end
         end
      end
      for (p = 0; p < n; p++) begin
         perm[p] = VAL_W'(1);
         filled[p] = 1'b0;
      end
      // item l lands in the free slot whose rank is digit l-1
      for (l = n; l >= 2; l--) begin
         rank = counter_digits[l-1];
         seen = 0;
         for (p = 0; p < n; p++) begin
            if (!filled[p]) begin
               if (seen == rank) begin
                  filled[p] = 1'b1;
                  perm[p] = VAL_W'(l);
                  break;
               end
               seen++;
            end
         end
      end
      for (p = 0; p < n; p++)
         dst.push_back('{position: POS_W'(p), value: perm[p], status: st,
                         last: (p + 1 == n)});
   endtask

   // words read straight off the table: n..1 or one invalid word
   task automatic add_typed_words(input status_type st);
      int p;
      if (st == ST_INVALID) begin
         pending_words.push_back('{position: '0, value: '0, status: ST_INVALID, last: 1'b1});
      end else begin
         for (p = 0; p < model_count; p++)
            pending_words.push_back('{position: POS_W'(p), value: VAL_W'(model_count - p),
                                      status: st, last: (p + 1 == model_count)});
      end
   endtask

   // offer one request word and record what it should produce
   task automatic send_request(input bit restart, input bit typed, input status_type st);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed) begin
         discarded_words.delete();
         step_and_decode(restart, discarded_words);
         add_typed_words(st);
      end else begin
         step_and_decode(restart, pending_words);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // count writes only with the block idle
   task automatic write_item_count(input logic [CNT_W-1:0] count);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_item_count <= count;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      model_count = count;
   endtask

   // result checker and receiver stall driver
   always @(posedge clock) begin
      perm_word_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word position %0d value %0d",
                                      rsp_position, rsp_value));
         end else begin
            want = pending_words.pop_front();
            check_field("position", rsp_position, want.position);
            check_field("value", rsp_value, want.value);
            check_field("status", rsp_status, want.status);
            check_field("last", rsp_last, want.last);
         end
      end
      if (hold_taken != hold_asked) begin
         hold_taken = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog on cycles with no word moving anywhere
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int items;
      foreach (counter_digits[k]) counter_digits[k] = '0;
      counter_fresh = 1'b1;
      model_count = ITEM_COUNT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, no idling
      foreach (directed_rows[r]) begin
         if (directed_rows[r].cfg != NO_WRITE)
            write_item_count(CNT_W'(directed_rows[r].cfg));
         send_request(directed_rows[r].restart, directed_rows[r].typed,
                      directed_rows[r].status);
      end

      // random phases over counts and idling patterns
      phase_counts[8] = $urandom_range(7, MAX_ITEMS);
      for (int ph = 0; ph < PHASES; ph++) begin
         write_item_count(CNT_W'(phase_counts[ph]));
         case (ph % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 87; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 87; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase
         // long receiver hold while the sender keeps offering
         if (ph == 0) hold_asked++;
         items = (phase_counts[ph] == 0) ? 8 : 44;
         for (int i = 0; i < items; i++) begin
            if (i == items / 2) wait_drained();
            send_request($urandom_range(9) == 0, 1'b0, ST_OK);
         end
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== permutation_sequence_generator.f =====
hdl/psg_pkg.sv
hdl/psg_ctrl.sv
hdl/psg_dpath.sv
hdl/permutation_sequence_generator.sv
sim/tb.sv
